[rtl/core/assert_macros.svh]
//------------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the mouse packet decoder modules.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset
`define MPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check on every clock edge, reset included
`define MPD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

[rtl/core/mpd_pkg.sv]
//------------------------------------------------------------------------------
// mpd_pkg
// Shared types and constants of the mouse packet decoder.
//------------------------------------------------------------------------------
package mpd_pkg;

    // Packet formats, as held in the format register
    localparam logic FMT_THREE = 1'b0;
    localparam logic FMT_FIVE  = 1'b1;

    // Register select, taken from paddr bit 2
    localparam logic REG_FORMAT = 1'b0;
    localparam logic REG_SCALE  = 1'b1;

    localparam int          PKT_MAX       = 5;
    localparam logic [2:0]  LEN_THREE     = 3'd3;
    localparam logic [2:0]  LEN_FIVE      = 3'd5;
    localparam logic [2:0]  SCALE_RESET   = 3'd2;
    localparam logic [7:0]  BYTE0_RESET   = 8'h07;
    localparam logic [7:0]  SYNC_MASK     = 8'hF8;
    localparam logic [7:0]  SYNC_VALUE    = 8'h80;
    localparam logic [2:0]  BUTTON_INVERT = 3'h7;

    localparam int QUEUE_DEPTH_DEF = 2;

    // One complete, checked packet on its way to the back end
    typedef struct packed {
        logic [2:0] buttons;
        logic [7:0] dx_a;
        logic [7:0] dx_b;
        logic [7:0] dy_a;
        logic [7:0] dy_b;
    } pkt_t;

endpackage

[rtl/core/mouse_packet_decoder.sv]
// Mouse packet decoder: accepts one received byte per cycle on s_ and emits one
// motion/button item on m_ for each good packet (three-byte or five-byte format,
// chosen by the format register). A completed packet goes through a small queue
// (QUEUE_DEPTH entries) to the back end, whose output register loads it from the
// queue head once it is free or being read out. s_tready drops only
// when the queue is full, which takes a stalled m_ side and several packets. Write
// the format and scale registers only while no packet is in flight.
//------------------------------------------------------------------------------
// mouse_packet_decoder
// Top level: configuration registers, front end, packet queue and back end.
//------------------------------------------------------------------------------
module mouse_packet_decoder
    import mpd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Byte input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // Result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [11:0] delta_x, [23:12] delta_y, [26:24] buttons
);

    logic              fmt_reg;
    logic [2:0]        scale_reg;
    logic              cfg_write;

    logic              byte_valid;
    logic              push, pop, q_full, q_valid;
    pkt_t              push_pkt, head_pkt;
    logic signed [11:0] delta_x, delta_y;
    logic [2:0]        buttons;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg   <= FMT_THREE;
            scale_reg <= SCALE_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_FORMAT) begin
                fmt_reg <= pwdata[0];
            end else begin
                scale_reg <= pwdata[2:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_SCALE) ? {29'd0, scale_reg} : {31'd0, fmt_reg};

    // Front end takes a byte whenever the queue has room
    assign s_tready   = !q_full;
    assign byte_valid = s_tvalid && s_tready;

    mpd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fmt      (fmt_reg),
        .byte_valid(byte_valid),
        .rx_byte  (s_tdata),
        .push     (push),
        .push_pkt (push_pkt)
    );

    mpd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_pkt (push_pkt),
        .pop      (pop),
        .full     (q_full),
        .not_empty(q_valid),
        .head_pkt (head_pkt)
    );

    mpd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .scale     (scale_reg),
        .head_valid(q_valid),
        .head_pkt  (head_pkt),
        .pop       (pop),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .delta_x   (delta_x),
        .delta_y   (delta_y),
        .buttons   (buttons)
    );

    assign m_tdata = {5'd0, buttons, delta_y, delta_x};

endmodule

[rtl/core/mpd_front.sv]
//------------------------------------------------------------------------------
// mpd_front
// Takes received bytes, tracks packet position, restart and discard, and
// pushes each good packet into the queue.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module mpd_front
    import mpd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fmt,
    input  logic       byte_valid,
    input  logic [7:0] rx_byte,
    output logic       push,
    output pkt_t       push_pkt
);

    logic [2:0] pos_reg, pos_next;
    logic       drop_reg, drop_next;
    logic [7:0] bytes_reg [PKT_MAX];
    logic [7:0] cur [PKT_MAX];

    logic       restart;
    logic [2:0] pos_eff;
    logic [2:0] pos_inc;
    logic [2:0] pkt_len;
    logic       sign_ok;

    assign restart = (fmt == FMT_FIVE) && ((rx_byte & SYNC_MASK) == SYNC_VALUE);
    assign pos_eff = restart ? 3'd0 : pos_reg;
    assign pos_inc = pos_eff + 3'd1;
    assign pkt_len = (fmt == FMT_FIVE) ? LEN_FIVE : LEN_THREE;

    // Packet as it stands with this byte placed
    always_comb begin
        for (int i = 0; i < PKT_MAX; i++) begin
            cur[i] = (pos_eff == 3'(i)) ? rx_byte : bytes_reg[i];
        end
    end

    assign sign_ok = (cur[0][5:4] == {cur[2][7], cur[1][7]});

    // Position, discard flag and push decision
    always_comb begin
        pos_next  = pos_reg;
        drop_next = drop_reg;
        push      = 1'b0;
        if (byte_valid) begin
            if (drop_reg) begin
                drop_next = 1'b0;
                pos_next  = pos_eff;
            end else if (pos_inc < pkt_len) begin
                pos_next = pos_inc;
            end else begin
                pos_next = 3'd0;
                if (fmt == FMT_THREE && !sign_ok) begin
                    drop_next = 1'b1;
                end else begin
                    push = 1'b1;
                end
            end
        end
    end

    // Packet record for the back end
    always_comb begin
        push_pkt.dx_a = cur[1];
        push_pkt.dy_a = cur[2];
        if (fmt == FMT_FIVE) begin
            push_pkt.dx_b    = cur[3];
            push_pkt.dy_b    = cur[4];
            push_pkt.buttons = cur[0][2:0];
        end else begin
            push_pkt.dx_b    = 8'd0;
            push_pkt.dy_b    = 8'd0;
            push_pkt.buttons = {cur[0][0], cur[0][2:1]} ^ BUTTON_INVERT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= 3'd0;
            drop_reg <= 1'b0;
        end else begin
            pos_reg  <= pos_next;
            drop_reg <= drop_next;
        end
    end

    // Store the byte at its place unless it is discarded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PKT_MAX; i++) begin
                bytes_reg[i] <= (i == 0) ? BYTE0_RESET : 8'd0;
            end
        end else if (byte_valid && !drop_reg) begin
            bytes_reg[pos_eff] <= rx_byte;
        end
    end

    `MPD_ASSERT(a_pos_range, pos_reg < LEN_FIVE, "byte position out of range")
    `MPD_ASSERT(a_drop_no_push, drop_reg |-> !push, "discarded byte completed a packet")

endmodule

[rtl/core/mpd_queue.sv]
//------------------------------------------------------------------------------
// mpd_queue
// Small packet queue between front and back end.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module mpd_queue
    import mpd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  pkt_t push_pkt,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output pkt_t head_pkt
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pkt_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_pkt  = mem_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_pkt;
        end
    end

    `MPD_ASSERT(a_no_overflow, full |-> !push, "push into full queue")
    `MPD_ASSERT(a_no_underflow, pop |-> not_empty, "pop from empty queue")

endmodule

[rtl/core/mpd_back.sv]
//------------------------------------------------------------------------------
// mpd_back
// Sums and scales the deltas of one packet and holds the result for output.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module mpd_back
    import mpd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [2:0]        scale,
    input  logic              head_valid,
    input  pkt_t              head_pkt,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic signed [11:0] delta_x,
    output logic signed [11:0] delta_y,
    output logic [2:0]        buttons
);

    logic               valid_reg, valid_next;
    logic signed [11:0] dx_reg, dy_reg;
    logic [2:0]         btn_reg;

    logic signed [11:0] sum_x, neg_y;
    logic signed [3:0]  scale_s;
    logic signed [15:0] prod_x, prod_y;

    assign pop = head_valid && (!valid_reg || m_ready);

    // Sum the delta pairs, negate Y, apply scale
    assign sum_x   = $signed({{4{head_pkt.dx_a[7]}}, head_pkt.dx_a})
                   + $signed({{4{head_pkt.dx_b[7]}}, head_pkt.dx_b});
    assign neg_y   = 12'sd0 - $signed({{4{head_pkt.dy_a[7]}}, head_pkt.dy_a})
                   - $signed({{4{head_pkt.dy_b[7]}}, head_pkt.dy_b});
    assign scale_s = $signed({1'b0, scale});
    assign prod_x  = 16'(sum_x * scale_s);
    assign prod_y  = 16'(neg_y * scale_s);

    always_comb begin
        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load the output register on pop
    always_ff @(posedge aclk) begin
        if (pop) begin
            dx_reg  <= prod_x[11:0];
            dy_reg  <= prod_y[11:0];
            btn_reg <= head_pkt.buttons;
        end
    end

    assign m_valid = valid_reg;
    assign delta_x = dx_reg;
    assign delta_y = dy_reg;
    assign buttons = btn_reg;

    `MPD_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !valid_reg, "output valid after reset")
    `MPD_ASSERT(a_hold_stalled, valid_reg && !m_ready |=> valid_reg && $stable(dx_reg),
        "stalled result lost")

endmodule

[tb/testbench.sv]
//------------------------------------------------------------------------------
// testbench
// Self-checking bench for the mouse packet decoder. Bytes go in on the s_
// stream and decoded motion/button items come out on the m_ stream. A directed
// table covers reset values, the delta and button extremes, the sign check,
// the discard rule, packet restarts and format changes in the middle of a
// packet. Random phases with fresh register settings follow, mostly
// well-formed packets with some broken ones and noise. Every output item is
// compared against a behavioral predictor or, for ROW_WANT rows, against the
// expected item typed in the table, and both streams stall in random bursts.
//------------------------------------------------------------------------------
module testbench
    import mpd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         N_RANDOM   = 950;
    localparam int         CALM_ITEMS = 100;
    localparam int         DRAIN_GAP  = 8;
    localparam int         END_GAP    = 20;
    localparam int         IDLE_LIMIT = 1000;
    localparam logic [2:0] ADDR_FORMAT = {REG_FORMAT, 2'b00};
    localparam logic [2:0] ADDR_SCALE  = {REG_SCALE, 2'b00};
    localparam logic [7:0] SIGN_BITS   = 8'h30;

    typedef struct packed {
        logic [2:0]  buttons;
        logic [11:0] dy;
        logic [11:0] dx;
    } motion_t;

    typedef enum logic [1:0] {ROW_BYTE, ROW_WANT, ROW_FMT, ROW_SCALE} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [7:0]  val;
        logic [11:0] dx;
        logic [11:0] dy;
        logic [2:0]  btn;
    } dir_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [11:0] delta_x, [23:12] delta_y, [26:24] buttons

    // Predictor state
    logic       cur_fmt   = FMT_THREE;
    logic [2:0] cur_scale = SCALE_RESET;
    logic [2:0] byte_idx  = '0;
    logic [7:0] pkt_buf [PKT_MAX] = '{BYTE0_RESET, 8'h00, 8'h00, 8'h00, 8'h00};
    logic       skip_next = 1'b0;

    motion_t motion_q[$];
    int      n_errors   = 0;
    int      idle_count = 0;
    int      stall_left = 0;
    bit      calm       = 1'b0;

    logic [2:0] scale_corner [4] = '{3'd0, 3'd7, 3'd1, 3'd4};

    // Directed stimulus; ROW_WANT rows carry the expected item typed in
    dir_row_t dir_rows[$] = '{
        // reset settings, zero motion
        '{ROW_BYTE,  8'h08, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h00, 12'h000, 12'h000, 3'd0},
        '{ROW_WANT,  8'h00, 12'h000, 12'h000, 3'd7},
        // largest positive deltas, all buttons down
        '{ROW_BYTE,  8'h0F, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h7F, 12'h000, 12'h000, 3'd0},
        '{ROW_WANT,  8'h7F, 12'h0FE, 12'hF02, 3'd0},
        // largest negative deltas
        '{ROW_BYTE,  8'h38, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h80, 12'h000, 12'h000, 3'd0},
        '{ROW_WANT,  8'h80, 12'hF00, 12'h100, 3'd7},
        // sign mismatch, then the discarded byte
        '{ROW_BYTE,  8'h08, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h80, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h00, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'hAA, 12'h000, 12'h000, 3'd0},
        // zero scale
        '{ROW_SCALE, 8'h00, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h18, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'hFF, 12'h000, 12'h000, 3'd0},
        '{ROW_WANT,  8'h00, 12'h000, 12'h000, 3'd7},
        // largest scale, largest magnitude
        '{ROW_SCALE, 8'h07, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h3B, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h80, 12'h000, 12'h000, 3'd0},
        '{ROW_WANT,  8'h80, 12'hC80, 12'h380, 3'd2},
        // switch to five bytes in the middle of a packet
        '{ROW_BYTE,  8'h08, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h01, 12'h000, 12'h000, 3'd0},
        '{ROW_FMT,   8'h01, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h02, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h03, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h04, 12'h000, 12'h000, 3'd0},
        // five-byte packet with largest sums
        '{ROW_SCALE, 8'h01, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h87, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h7F, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h88, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h7F, 12'h000, 12'h000, 3'd0},
        '{ROW_WANT,  8'h88, 12'h0FE, 12'h0F0, 3'd7},
        // back to three bytes in the middle of a packet
        '{ROW_BYTE,  8'h81, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h05, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h06, 12'h000, 12'h000, 3'd0},
        '{ROW_FMT,   8'h00, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h07, 12'h000, 12'h000, 3'd0},
        // pending discard meets a restart byte, then a restart mid-packet
        '{ROW_BYTE,  8'h00, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h80, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h80, 12'h000, 12'h000, 3'd0},
        '{ROW_FMT,   8'h01, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h81, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h81, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h01, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h02, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h82, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h01, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h02, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h03, 12'h000, 12'h000, 3'd0},
        '{ROW_BYTE,  8'h04, 12'h000, 12'h000, 3'd0}
    };

    mouse_packet_decoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    // Advance the packet state by one byte; return 1 when a motion item results
    function automatic bit decode_byte(input logic [7:0] c, output motion_t ev);
        logic [2:0] len;
        logic [7:0] b0;
        logic [7:0] sign_want;
        int         dxs;
        int         dys;
        ev = '0;
        len = (cur_fmt == FMT_FIVE) ? LEN_FIVE : LEN_THREE;
        if (cur_fmt == FMT_FIVE && (c & SYNC_MASK) == SYNC_VALUE)
            byte_idx = '0;
        if (skip_next) begin
            skip_next = 1'b0;
            return 1'b0;
        end
        if (byte_idx < PKT_MAX)
            pkt_buf[byte_idx] = c;
        byte_idx = byte_idx + 3'd1;
        if (byte_idx < len)
            return 1'b0;
        byte_idx = '0;
        b0 = pkt_buf[0];
        if (cur_fmt == FMT_THREE) begin
            sign_want = {2'b00, pkt_buf[2][7], pkt_buf[1][7], 4'h0};
            if ((b0 & SIGN_BITS) != sign_want) begin
                skip_next = 1'b1;
                return 1'b0;
            end
            dxs = $signed(pkt_buf[1]);
            dys = -$signed(pkt_buf[2]);
            ev.buttons = {b0[0], b0[2:1]} ^ BUTTON_INVERT;
        end else begin
            dxs = $signed(pkt_buf[1]) + $signed(pkt_buf[3]);
            dys = -($signed(pkt_buf[2]) + $signed(pkt_buf[4]));
            ev.buttons = b0[2:0];
        end
        dxs = dxs * int'(cur_scale);
        dys = dys * int'(cur_scale);
        ev.dx = dxs[11:0];
        ev.dy = dys[11:0];
        return 1'b1;
    endfunction

    // Random delta byte that cannot be taken for a restart byte
    function automatic logic [7:0] plain_delta();
        logic [7:0] d;
        d = 8'($urandom);
        while ((d & SYNC_MASK) == SYNC_VALUE)
            d = 8'($urandom);
        return d;
    endfunction

    // Offer one item on s_, with an occasional idle burst first
    task automatic send_byte(input logic [7:0] b, input logic [11:0] w_dx,
                             input logic [11:0] w_dy, input logic [2:0] w_btn,
                             input bit typed);
        motion_t ev;
        if (!calm && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        if (decode_byte(b, ev) || typed) begin
            if (typed)
                ev = '{w_btn, w_dy, w_dx};
            motion_q.push_back(ev);
        end
    endtask

    // Hold the sender until every expected item is out, then let the back end settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (motion_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);
    endtask

    // Write a register, then read it back
    task automatic cfg_write(input logic [2:0] addr, input logic [31:0] val);
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_FORMAT) begin
            cur_fmt = val[0];
            want    = {31'b0, val[0]};
        end else begin
            cur_scale = val[2:0];
            want      = {29'b0, val[2:0]};
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) begin
            $display("%0t: register %0d readback expected %h got %h", $realtime, addr,
                     want, prdata);
            n_errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Result side: random stalls and the item check
    always @(posedge aclk) begin
        motion_t got;
        motion_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[26:0];
            if (motion_q.size() == 0) begin
                $display("%0t: unexpected item, expected none got %h", $realtime, m_tdata);
                n_errors++;
            end else begin
                want = motion_q.pop_front();
                if (got.dx !== want.dx) begin
                    $display("%0t: delta_x expected %h got %h", $realtime, want.dx, got.dx);
                    n_errors++;
                end
                if (got.dy !== want.dy) begin
                    $display("%0t: delta_y expected %h got %h", $realtime, want.dy, got.dy);
                    n_errors++;
                end
                if (got.buttons !== want.buttons) begin
                    $display("%0t: buttons expected %h got %h", $realtime, want.buttons,
                             got.buttons);
                    n_errors++;
                end
            end
        end
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles with no accepted item on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int         sent;
        int         phase;
        int         phase_end;
        int         r;
        int         k;
        int         n_part;
        logic [2:0] scale_pick;
        logic [7:0] dxb;
        logic [7:0] dyb;
        logic [7:0] b0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table
        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_FMT: begin
                    drain();
                    cfg_write(ADDR_FORMAT, {24'b0, dir_rows[i].val});
                end
                ROW_SCALE: begin
                    drain();
                    cfg_write(ADDR_SCALE, {24'b0, dir_rows[i].val});
                end
                default: begin
                    send_byte(dir_rows[i].val, dir_rows[i].dx, dir_rows[i].dy,
                              dir_rows[i].btn, dir_rows[i].kind == ROW_WANT);
                end
            endcase
        end

        // Random phases, each with its own register settings
        sent  = 0;
        phase = 0;
        while (sent < N_RANDOM) begin
            drain();
            scale_pick = (phase < 4) ? scale_corner[phase] : 3'($urandom_range(0, 7));
            cfg_write(ADDR_FORMAT, {31'b0, phase[0] ^ 1'($urandom_range(0, 1))});
            cfg_write(ADDR_SCALE, {29'b0, scale_pick});
            phase_end = sent + $urandom_range(30, 110);
            while (sent < phase_end && sent < N_RANDOM) begin
                calm = (sent >= N_RANDOM - CALM_ITEMS);
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    // hold off until the decoder has caught up
                    drain();
                end else if (r < 13) begin
                    send_byte(8'($urandom), '0, '0, '0, 1'b0);
                    sent++;
                end else if (cur_fmt == FMT_THREE) begin
                    dxb = 8'($urandom);
                    dyb = 8'($urandom);
                    b0  = {2'($urandom), dyb[7], dxb[7], 4'($urandom)};
                    if (r < 23)
                        b0[4 + $urandom_range(0, 1)] ^= 1'b1;
                    send_byte(b0, '0, '0, '0, 1'b0);
                    send_byte(dxb, '0, '0, '0, 1'b0);
                    send_byte(dyb, '0, '0, '0, 1'b0);
                    sent += 3;
                end else begin
                    // broken packets stop short and let the next header restart
                    n_part = (r < 23) ? $urandom_range(0, 3) : 4;
                    send_byte({5'b10000, 3'($urandom)}, '0, '0, '0, 1'b0);
                    for (k = 0; k < n_part; k++)
                        send_byte(plain_delta(), '0, '0, '0, 1'b0);
                    sent += n_part + 1;
                end
            end
            phase++;
        end

        // Wait out the last items
        s_tvalid <= 1'b0;
        while (motion_q.size() != 0) @(posedge aclk);
        repeat (END_GAP) @(posedge aclk);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
